>>> rtl/lpwmf_pkg.sv
`default_nettype none

package lpwmf_pkg;

    // Item opcodes
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_SET    = 2'd1;
    localparam logic [1:0] OP_TOGGLE = 2'd2;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SPEED_PERIOD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ON_POLARITY    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_OUT_HIGH  = 2'd2;

    // Register reset values
    localparam logic [7:0] SPEED_RESET     = 8'd10;
    localparam logic       POLARITY_RESET  = 1'b1;
    localparam logic       INIT_HIGH_RESET = 1'b0;

    // Output field width
    localparam int unsigned PWM_W = 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_CMP,
        ST_DIV,
        ST_APPLY,
        ST_FINISH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic mul;
        logic cmp;
        logic div_step;
        logic apply;
        logic load_out;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_div;
        logic cmp_ge;
    } status_t;

endpackage

`default_nettype wire

>>> rtl/lpwmf_ctrl.sv
`default_nettype none

module lpwmf_ctrl #(
    parameter int unsigned DIV_STEPS = 8
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  wire                  m_ready,
    input  lpwmf_pkg::status_t   status,
    output lpwmf_pkg::cmd_t      cmd
);

    localparam int unsigned CNT_W = $clog2(DIV_STEPS + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    lpwmf_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              m_valid_reg, m_valid_next;
    logic              out_free;

    assign out_free = !m_valid_reg || m_ready;

    // State, divide count, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lpwmf_pkg::ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            lpwmf_pkg::ST_IDLE: begin
                if (s_valid) state_next = lpwmf_pkg::ST_EXEC;
            end
            lpwmf_pkg::ST_EXEC: begin
                state_next = status.need_div ? lpwmf_pkg::ST_MUL : lpwmf_pkg::ST_FINISH;
            end
            lpwmf_pkg::ST_MUL: begin
                state_next = lpwmf_pkg::ST_CMP;
            end
            lpwmf_pkg::ST_CMP: begin
                cnt_next   = '0;
                state_next = status.cmp_ge ? lpwmf_pkg::ST_APPLY : lpwmf_pkg::ST_DIV;
            end
            lpwmf_pkg::ST_DIV: begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST) state_next = lpwmf_pkg::ST_APPLY;
            end
            lpwmf_pkg::ST_APPLY: begin
                state_next = lpwmf_pkg::ST_FINISH;
            end
            lpwmf_pkg::ST_FINISH: begin
                if (out_free) state_next = lpwmf_pkg::ST_IDLE;
            end
            default: begin
                state_next = lpwmf_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath commands
    always_comb begin
        cmd          = '0;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            lpwmf_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            lpwmf_pkg::ST_EXEC:  cmd.exec     = 1'b1;
            lpwmf_pkg::ST_MUL:   cmd.mul      = 1'b1;
            lpwmf_pkg::ST_CMP:   cmd.cmp      = 1'b1;
            lpwmf_pkg::ST_DIV:   cmd.div_step = 1'b1;
            lpwmf_pkg::ST_APPLY: cmd.apply    = 1'b1;
            lpwmf_pkg::ST_FINISH: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

    // Checks
    a_accept_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == lpwmf_pkg::ST_EXEC))
        else $error("accepted item did not enter execute");

    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lpwmf_pkg::ST_DIV) |-> (cnt_reg <= CNT_LAST))
        else $error("divide count out of range");

    a_valid_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == lpwmf_pkg::ST_FINISH))
        else $error("result valid raised outside finish");

endmodule

`default_nettype wire

>>> rtl/lpwmf_dp.sv
`default_nettype none

module lpwmf_dp #(
    parameter int unsigned LEVEL_MAX = 255
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  lpwmf_pkg::cmd_t                      cmd,
    output lpwmf_pkg::status_t                   status,
    input  wire [1:0]                            s_opcode,
    input  wire                                  s_requested_on,
    input  wire [31:0]                           s_now_ms,
    input  wire                                  s_psu_on,
    input  wire                                  cfg_we,
    input  wire [lpwmf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire [lpwmf_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    output logic [lpwmf_pkg::PWM_W-1:0]          m_pwm_level,
    output logic                                 m_pwm_write,
    output logic                                 m_light_on,
    output logic                                 m_needs_power,
    output logic                                 m_ramping
);

    localparam int unsigned LEVEL_W = $clog2(LEVEL_MAX + 1);
    localparam int unsigned DW      = LEVEL_W + 8;
    localparam logic [LEVEL_W-1:0] LVL_MAX = LEVEL_W'(LEVEL_MAX);

    // Configuration
    logic [7:0] speed_reg;
    logic       pol_reg;

    // Fade state
    logic [LEVEL_W-1:0] level_reg;
    logic               target_reg;
    logic               fade_reg;
    logic               start_reg;
    logic [31:0]        last_reg;

    // Captured item
    logic [1:0]  op_reg;
    logic        req_reg;
    logic [31:0] now_reg;
    logic        psu_reg;

    // Step arithmetic
    logic [31:0]        elapsed_reg;
    logic [LEVEL_W-1:0] room_reg;
    logic [DW-1:0]      prod_reg;
    logic [7:0]         rem_reg;
    logic [LEVEL_W-1:0] qd_reg;
    logic               wrote_reg;

    // Output payload
    logic [lpwmf_pkg::PWM_W-1:0] pwm_level_reg;
    logic pwm_write_reg, light_on_reg, needs_power_reg, ramping_reg;

    logic [LEVEL_W-1:0] level_start, level_end, eff_level, room;
    logic [31:0]        eff_last, elapsed;
    logic               tick_live, speed_zero, step_due, new_target, light;
    logic [8:0]         trial;
    logic               trial_ge;
    logic [LEVEL_W-1:0] lvl_up, lvl_dn;
    logic [DW-1:0]      lvl_ext;

    // Tick evaluation, with a pending start resolved first
    always_comb begin
        level_start = target_reg ? '0 : LVL_MAX;
        level_end   = target_reg ? LVL_MAX : '0;
        eff_level   = start_reg ? level_start : level_reg;
        eff_last    = start_reg ? now_reg : last_reg;
        elapsed     = now_reg - eff_last;
        tick_live   = (op_reg == lpwmf_pkg::OP_TICK) && fade_reg && (!start_reg || psu_reg);
        speed_zero  = (speed_reg == 8'd0);
        step_due    = (elapsed >= 32'(speed_reg));
        new_target  = req_reg ^ ~pol_reg;
        room        = target_reg ? (LVL_MAX - level_reg) : level_reg;
        trial       = {rem_reg, qd_reg[LEVEL_W-1]};
        trial_ge    = (trial >= {1'b0, speed_reg});
        lvl_up      = level_reg + qd_reg;
        lvl_dn      = level_reg - qd_reg;
        light       = target_reg ^ ~pol_reg;
        lvl_ext     = DW'(level_reg);
    end

    assign status.need_div = tick_live && !speed_zero && step_due;
    assign status.cmp_ge   = (elapsed_reg >= 32'(prod_reg));

    // Configuration registers and fade state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_reg     <= lpwmf_pkg::SPEED_RESET;
            pol_reg       <= lpwmf_pkg::POLARITY_RESET;
            level_reg     <= '0;
            target_reg    <= lpwmf_pkg::INIT_HIGH_RESET;
            fade_reg      <= 1'b0;
            start_reg     <= 1'b0;
            last_reg      <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    lpwmf_pkg::REG_SPEED_PERIOD: speed_reg <= cfg_wdata;
                    lpwmf_pkg::REG_ON_POLARITY:  pol_reg   <= cfg_wdata[0];
                    lpwmf_pkg::REG_INIT_OUT_HIGH: begin
                        target_reg    <= cfg_wdata[0];
                    end
                    default: ;
                endcase
            end
            if (cmd.exec) begin
                case (op_reg)
                    lpwmf_pkg::OP_TICK: begin
                        if (tick_live) begin
                            start_reg <= 1'b0;
                            if (speed_zero) begin
                                level_reg <= level_end;
                                last_reg  <= now_reg;
                                fade_reg  <= 1'b0;
                            end else begin
                                level_reg <= eff_level;
                                last_reg  <= step_due ? now_reg : eff_last;
                            end
                        end
                    end
                    lpwmf_pkg::OP_SET: begin
                        if (new_target != target_reg) begin
                            start_reg <= 1'b1;
                            fade_reg  <= 1'b1;
                        end
                        target_reg <= new_target;
                    end
                    lpwmf_pkg::OP_TOGGLE: begin
                        target_reg <= ~target_reg;
                        start_reg  <= 1'b1;
                        fade_reg   <= 1'b1;
                    end
                    default: ;
                endcase
            end
            // Step applied, fade ends at the rail
            if (cmd.apply) begin
                if (target_reg) begin
                    level_reg <= lvl_up;
                    if (lvl_up == LVL_MAX) fade_reg <= 1'b0;
                end else begin
                    level_reg <= lvl_dn;
                    if (lvl_dn == '0) fade_reg <= 1'b0;
                end
            end
        end
    end

    // Item capture, step count (clamp check then restoring divide), result
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg  <= s_opcode;
            req_reg <= s_requested_on;
            now_reg <= s_now_ms;
            psu_reg <= s_psu_on;
        end
        if (cmd.exec) begin
            elapsed_reg <= elapsed;
            wrote_reg   <= tick_live && speed_zero;
        end
        if (cmd.mul) begin
            room_reg <= room;
            prod_reg <= DW'(room) * DW'(speed_reg);
        end
        if (cmd.cmp) begin
            if (status.cmp_ge) begin
                qd_reg <= room_reg;
            end else begin
                // quotient fits LEVEL_W bits, so the top byte is below speed
                rem_reg <= elapsed_reg[DW-1:LEVEL_W];
                qd_reg  <= elapsed_reg[LEVEL_W-1:0];
            end
        end
        if (cmd.div_step) begin
            rem_reg <= trial_ge ? 8'(trial - {1'b0, speed_reg}) : trial[7:0];
            qd_reg  <= (qd_reg << 1) | LEVEL_W'(trial_ge);
        end
        if (cmd.apply) begin
            wrote_reg <= 1'b1;
        end
        if (cmd.load_out) begin
            pwm_level_reg   <= (lvl_ext > DW'(255)) ? 8'hFF : lvl_ext[7:0];
            pwm_write_reg   <= wrote_reg;
            light_on_reg    <= light;
            needs_power_reg <= light | fade_reg;
            ramping_reg     <= fade_reg;
        end
    end

    assign m_pwm_level   = pwm_level_reg;
    assign m_pwm_write   = pwm_write_reg;
    assign m_light_on    = light_on_reg;
    assign m_needs_power = needs_power_reg;
    assign m_ramping     = ramping_reg;

    // Checks
    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= LVL_MAX)
        else $error("level above maximum");

    a_start_in_fade: assert property (@(posedge aclk) disable iff (!aresetn)
        start_reg |-> fade_reg)
        else $error("pending start without fade");

endmodule

`default_nettype wire

>>> rtl/led_pwm_fade_controller_core.sv
// LED PWM fade controller.
// Input channel (s_valid/s_ready): one item per command: tick (time in ms and
// supply-ready flag), set (requested on/off) or toggle. Every item produces one
// result on the m_ channel: PWM level, a write strobe when the level moved by a
// ramp step or a zero-speed jump, the logical light state, power request and ramp status.
// Config port (cfg_we/cfg_index/cfg_wdata): speed period, on polarity and the
// initial raw output level; write only while the block is idle.
// From acceptance to result valid: set, toggle, zero-speed jumps and ticks that
// take no step go from execute straight to finish; a step clamped to the end of
// the ramp passes multiply, compare and apply; otherwise the step count comes
// from the one-bit-per-cycle divider between compare and apply. The next item is
// accepted back in idle. The divider (elapsed / speed) sets the worst case.
// Reset: level 0, no fade, target low, speed 10, active-high polarity.
// A stalled receiver holds the result in the output register; the block finishes
// the current item, then waits before loading its result and taking the next item.
`default_nettype none

module led_pwm_fade_controller_core #(
    parameter int unsigned LEVEL_MAX = 255
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire [1:0]                        s_opcode,
    input  wire                              s_requested_on,
    input  wire [31:0]                       s_now_ms,
    input  wire                              s_psu_on,
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic [lpwmf_pkg::PWM_W-1:0]      m_pwm_level,
    output logic                             m_pwm_write,
    output logic                             m_light_on,
    output logic                             m_needs_power,
    output logic                             m_ramping,
    input  wire                              cfg_we,
    input  wire [lpwmf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire [lpwmf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int unsigned LEVEL_W = $clog2(LEVEL_MAX + 1);

    lpwmf_pkg::cmd_t    cmd;
    lpwmf_pkg::status_t status;

    lpwmf_ctrl #(
        .DIV_STEPS (LEVEL_W)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    lpwmf_dp #(
        .LEVEL_MAX (LEVEL_MAX)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_opcode       (s_opcode),
        .s_requested_on (s_requested_on),
        .s_now_ms       (s_now_ms),
        .s_psu_on       (s_psu_on),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .m_pwm_level    (m_pwm_level),
        .m_pwm_write    (m_pwm_write),
        .m_light_on     (m_light_on),
        .m_needs_power  (m_needs_power),
        .m_ramping      (m_ramping)
    );

endmodule

`default_nettype wire
